[hw/rtl/scm_pkg.sv]
`timescale 1ns / 1ps

package scm_pkg;

  typedef enum logic [2:0] {
    OP_SAMPLE       = 3'd0,
    OP_ACK_BYPASS   = 3'd1,
    OP_CLEAR_BYPASS = 3'd2,
    OP_RESET_CYCLE  = 3'd3,
    OP_TRIP         = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    VS_UNKNOWN = 3'd0,
    VS_NORMAL  = 3'd1,
    VS_WARNING = 3'd2,
    VS_WAIT    = 3'd3,
    VS_BYPASS  = 3'd4,
    VS_LOCKED  = 3'd5
  } volt_state_e;

  typedef enum logic [1:0] {
    CS_NORMAL = 2'd0,
    CS_OVER   = 2'd1,
    CS_LOCKED = 2'd2
  } curr_state_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_BYPASS = 2'd1,
    ST_READ_FAIL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_CRITICAL_MV  = 3'd0,
    REG_CUT_MV       = 3'd1,
    REG_WARN_LOW_MV  = 3'd2,
    REG_RECOVER_MV   = 3'd3,
    REG_TRIP_MA      = 3'd4,
    REG_MAX_ATTEMPTS = 3'd5
  } cfg_idx_e;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  typedef struct packed {
    logic [15:0] critical_mv;
    logic [15:0] cut_mv;
    logic [15:0] warn_low_mv;
    logic [15:0] recover_mv;
    logic [14:0] trip_ma;
    logic [7:0]  max_attempts;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [15:0]        bus_mv;
    logic signed [15:0] load_ma;
    logic [31:0]        now_ms;
    logic               motor_on;
    logic               read_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  supply_state;
    logic [1:0]  load_state;
    logic        bypass_needed;
    logic        bypass_acked;
    logic [7:0]  trip_count;
    logic [31:0] bypass_elapsed;
    logic        safe_to_start;
    logic        overcurrent_flag;
    logic        locked_flag;
    logic [31:0] good_reads;
    logic [31:0] bad_reads;
  } out_item_t;

endpackage

[hw/rtl/scm_if.sv]
`timescale 1ns / 1ps

interface scm_in_if;
  logic               valid;
  logic               ready;
  scm_pkg::in_item_t  item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface scm_out_if;
  logic               valid;
  logic               ready;
  scm_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

[hw/rtl/scm_cfg.sv]
`timescale 1ns / 1ps

module scm_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [scm_pkg::CfgIdxWidth-1:0]      cfg_idx_i,
  input  logic [scm_pkg::CfgDataWidth-1:0]     cfg_wdata_i,
  output scm_pkg::cfg_t                        cfg_o
);

  scm_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (scm_pkg::cfg_idx_e'(cfg_idx_i))
        scm_pkg::REG_CRITICAL_MV:  cfg_d.critical_mv  = cfg_wdata_i;
        scm_pkg::REG_CUT_MV:       cfg_d.cut_mv       = cfg_wdata_i;
        scm_pkg::REG_WARN_LOW_MV:  cfg_d.warn_low_mv  = cfg_wdata_i;
        scm_pkg::REG_RECOVER_MV:   cfg_d.recover_mv   = cfg_wdata_i;
        scm_pkg::REG_TRIP_MA:      cfg_d.trip_ma      = cfg_wdata_i[14:0];
        scm_pkg::REG_MAX_ATTEMPTS: cfg_d.max_attempts = cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{critical_mv: 16'd0, cut_mv: 16'd0, warn_low_mv: 16'd0,
                 recover_mv: 16'd0, trip_ma: 15'd1, max_attempts: 8'd1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/scm_core.sv]
`timescale 1ns / 1ps

module scm_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  scm_pkg::in_item_t   item_i,
  input  scm_pkg::cfg_t       cfg_i,
  output scm_pkg::out_item_t  result_o
);

  scm_pkg::volt_state_e vs_q, vs_d, vs_class;
  scm_pkg::curr_state_e cs_q, cs_d;
  scm_pkg::status_e     status;
  logic        req_q, req_d, ack_q, ack_d, lock_q, lock_d, valid_q, valid_d;
  logic [7:0]  att_q, att_d, att_inc;
  logic [31:0] start_q, start_d, elapsed_q, elapsed_d;
  logic [15:0] last_q, last_d;
  logic [31:0] ok_q, ok_d, fail_q, fail_d;
  logic        below_cut, below_rec, over_trip;

  assign below_cut = item_i.bus_mv < cfg_i.cut_mv;
  assign below_rec = item_i.bus_mv < cfg_i.recover_mv;
  assign over_trip = item_i.load_ma >= $signed({1'b0, cfg_i.trip_ma});
  assign att_inc   = (att_q < cfg_i.max_attempts) ? att_q + 8'd1 : att_q;

  always_comb begin
    if (item_i.bus_mv < cfg_i.critical_mv) begin
      vs_class = scm_pkg::VS_LOCKED;
    end else if (vs_q == scm_pkg::VS_LOCKED && below_rec) begin
      vs_class = scm_pkg::VS_LOCKED;
    end else if (vs_q == scm_pkg::VS_BYPASS && below_rec) begin
      vs_class = scm_pkg::VS_BYPASS;
    end else if (item_i.motor_on && below_cut) begin
      vs_class = scm_pkg::VS_WAIT;
    end else if (item_i.bus_mv < cfg_i.warn_low_mv) begin
      vs_class = scm_pkg::VS_WARNING;
    end else begin
      vs_class = scm_pkg::VS_NORMAL;
    end
  end

  always_comb begin
    vs_d      = vs_q;
    cs_d      = cs_q;
    req_d     = req_q;
    ack_d     = ack_q;
    lock_d    = lock_q;
    valid_d   = valid_q;
    att_d     = att_q;
    start_d   = start_q;
    elapsed_d = elapsed_q;
    last_d    = last_q;
    ok_d      = ok_q;
    fail_d    = fail_q;
    status    = scm_pkg::ST_OK;
    case (scm_pkg::opcode_e'(item_i.opcode))
      scm_pkg::OP_SAMPLE: begin
        if (!item_i.read_ok) begin
          fail_d  = fail_q + 32'd1;
          valid_d = 1'b0;
          cs_d    = scm_pkg::CS_NORMAL;
          status  = scm_pkg::ST_READ_FAIL;
        end else begin
          ok_d    = ok_q + 32'd1;
          last_d  = item_i.bus_mv;
          valid_d = 1'b1;
          vs_d    = vs_class;
          if (vs_class == scm_pkg::VS_LOCKED) begin
            req_d     = 1'b0;
            ack_d     = 1'b0;
            start_d   = '0;
            elapsed_d = '0;
          end else if (item_i.motor_on && below_cut) begin
            if (!req_q) begin
              req_d     = 1'b1;
              ack_d     = 1'b0;
              start_d   = item_i.now_ms;
              elapsed_d = '0;
            end else begin
              elapsed_d = item_i.now_ms - start_q;
            end
            vs_d = ack_d ? scm_pkg::VS_BYPASS : scm_pkg::VS_WAIT;
          end else begin
            if (!below_rec) begin
              req_d     = 1'b0;
              ack_d     = 1'b0;
              start_d   = '0;
              elapsed_d = '0;
              vs_d      = scm_pkg::VS_NORMAL;
            end
            if (over_trip) begin
              cs_d = scm_pkg::CS_OVER;
            end else if (!lock_q) begin
              cs_d = scm_pkg::CS_NORMAL;
            end
          end
        end
      end
      scm_pkg::OP_ACK_BYPASS: begin
        if (!req_q) begin
          status = scm_pkg::ST_NO_BYPASS;
        end else begin
          ack_d = 1'b1;
          vs_d  = scm_pkg::VS_BYPASS;
        end
      end
      scm_pkg::OP_CLEAR_BYPASS: begin
        req_d     = 1'b0;
        ack_d     = 1'b0;
        start_d   = '0;
        elapsed_d = '0;
        if (valid_q) begin
          if (last_q >= cfg_i.recover_mv) begin
            vs_d = scm_pkg::VS_NORMAL;
          end else if (last_q < cfg_i.warn_low_mv) begin
            vs_d = scm_pkg::VS_WARNING;
          end
        end
      end
      scm_pkg::OP_RESET_CYCLE: begin
        att_d     = '0;
        lock_d    = 1'b0;
        if (cs_q == scm_pkg::CS_LOCKED) begin
          cs_d = scm_pkg::CS_NORMAL;
        end
        req_d     = 1'b0;
        ack_d     = 1'b0;
        start_d   = '0;
        elapsed_d = '0;
      end
      scm_pkg::OP_TRIP: begin
        att_d = att_inc;
        cs_d  = scm_pkg::CS_OVER;
        if (att_inc >= cfg_i.max_attempts) begin
          lock_d = 1'b1;
          cs_d   = scm_pkg::CS_LOCKED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q      <= scm_pkg::VS_UNKNOWN;
      cs_q      <= scm_pkg::CS_NORMAL;
      req_q     <= 1'b0;
      ack_q     <= 1'b0;
      lock_q    <= 1'b0;
      valid_q   <= 1'b0;
      att_q     <= '0;
      start_q   <= '0;
      elapsed_q <= '0;
      last_q    <= '0;
      ok_q      <= '0;
      fail_q    <= '0;
    end else if (step_i) begin
      vs_q      <= vs_d;
      cs_q      <= cs_d;
      req_q     <= req_d;
      ack_q     <= ack_d;
      lock_q    <= lock_d;
      valid_q   <= valid_d;
      att_q     <= att_d;
      start_q   <= start_d;
      elapsed_q <= elapsed_d;
      last_q    <= last_d;
      ok_q      <= ok_d;
      fail_q    <= fail_d;
    end
  end

  always_comb begin
    result_o.status           = status;
    result_o.supply_state     = vs_d;
    result_o.load_state       = cs_d;
    result_o.bypass_needed    = req_d;
    result_o.bypass_acked     = ack_d;
    result_o.trip_count       = att_d;
    result_o.bypass_elapsed   = elapsed_d;
    result_o.safe_to_start    = valid_d && (last_d >= cfg_i.cut_mv)
                                && (last_d >= cfg_i.critical_mv)
                                && (vs_d != scm_pkg::VS_LOCKED) && !req_d;
    result_o.overcurrent_flag = (cs_d == scm_pkg::CS_OVER) || (cs_d == scm_pkg::CS_LOCKED);
    result_o.locked_flag      = (vs_d == scm_pkg::VS_LOCKED) || (cs_d == scm_pkg::CS_LOCKED);
    result_o.good_reads       = ok_d;
    result_o.bad_reads        = fail_d;
  end

`ifndef SYNTH
  a_cs_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cs_q == scm_pkg::CS_LOCKED |-> lock_q)
    else $error("current locked without lock bit");
  a_ack_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ack_q |-> req_q)
    else $error("bypass acked without request");
  a_vlock_nobyp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vs_q == scm_pkg::VS_LOCKED |-> !req_q)
    else $error("bypass request while voltage locked");
  a_reset_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.opcode == scm_pkg::OP_RESET_CYCLE |=> att_q == '0 && !lock_q)
    else $error("reset cycle left attempts or lock");
`endif

endmodule

[hw/rtl/supply_condition_monitor.sv]
`timescale 1ns / 1ps
// Supply condition monitor.
// Input channel in_i carries one sample or event item; output channel out_o
// returns exactly one result item per input item, in order.
// Configuration: write cfg_wdata_i to register cfg_idx_i while cfg_we_i is
// high; write only while no item is in flight. Unknown indexes are dropped.
// Datapath: an input register, one level of compare/subtract logic that also
// updates the monitor state, and an output register.
// Order: an accepted item is held in the input register; its result is registered
// in the output register when the input register advances, which raises out_o.valid.
// Throughput: one item per cycle while out_o.ready stays high; set by the single state-update step.
// Reset: all monitor state, counters and both stages clear; thresholds return
// to zero, trip level and attempt limit to one.
// Stall: while out_o.ready is low the output register holds its item, the
// input register fills, and in_i.ready drops once both are full.
module supply_condition_monitor (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  scm_in_if.sink                           in_i,
  scm_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [scm_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [scm_pkg::CfgDataWidth-1:0] cfg_wdata_i
);

  scm_pkg::cfg_t      cfg;
  scm_pkg::in_item_t  s1_item_q;
  scm_pkg::out_item_t result, out_item_q;
  logic               s1_valid_q, out_valid_q, s1_adv, in_acc;

  assign s1_adv   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc   = in_i.valid && in_i.ready;

  scm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  scm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .item_i   (s1_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_i.item;
    end
    if (s1_adv) begin
      out_item_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;

endmodule
